@@ src/greedy_word_wrap_chunker_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the word wrap chunker
// Each macro checks a property on the rising edge of clk_i. Defining
// ASSERT_OFF turns every check into empty text.
// ----------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_CHUNKER_UNIT_DEFINES_SVH
`define GREEDY_WORD_WRAP_CHUNKER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// The check is suspended while rst_ni is low.
`define GWWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// The check also runs while reset is applied.
`define GWWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GWWC_ASSERT(lbl, prop, msg)
`define GWWC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/gwwc_pkg.sv @@
// ----------------------------------------------------------------------------
// gwwc_pkg
// Shared constants and types of the word wrap chunker.
// ----------------------------------------------------------------------------
package gwwc_pkg;

  // Largest chunk width the buffers are sized for.
  localparam int unsigned MAX_WIDTH_DEF = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned LINE_W     = 6;
  localparam int unsigned MAXC_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNKS = 2'd1;

  localparam logic [LINE_W-1:0] LINE_WIDTH_RST = 6'd16;
  localparam logic [MAXC_W-1:0] MAX_CHUNKS_RST = 8'd128;

  // Characters that separate words.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [LINE_W-1:0] line_width;
    logic [MAXC_W-1:0] max_chunks;
  } cfg_regs_t;

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);
  endfunction

endpackage

@@ src/gwwc_in_if.sv @@
// ----------------------------------------------------------------------------
// gwwc_in_if
// Byte channel into the chunker: one message byte per transfer.
// ----------------------------------------------------------------------------
interface gwwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

@@ src/gwwc_out_if.sv @@
// ----------------------------------------------------------------------------
// gwwc_out_if
// Result channel of the chunker: one chunk character or marker per transfer.
// ----------------------------------------------------------------------------
interface gwwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       no_char;
  logic [7:0] chunk_index;
  logic       end_of_chunk;
  logic       end_of_message;

  modport source (
    output valid, output out_char, output no_char, output chunk_index,
    output end_of_chunk, output end_of_message, input ready
  );
  modport sink (
    input valid, input out_char, input no_char, input chunk_index,
    input end_of_chunk, input end_of_message, output ready
  );
endinterface

@@ src/gwwc_ram.sv @@
// ----------------------------------------------------------------------------
// gwwc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gwwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/gwwc_cfg.sv @@
// ----------------------------------------------------------------------------
// gwwc_cfg
// Configuration registers: chunk width and chunk limit per message.
// ----------------------------------------------------------------------------
module gwwc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [gwwc_pkg::CFG_IDX_W-1:0]      idx_i,
  input  logic [gwwc_pkg::CFG_DATA_W-1:0]     wdata_i,
  input  logic                                saw_text_i,
  output gwwc_pkg::cfg_regs_t                 regs_o
);

  gwwc_pkg::cfg_regs_t regs_q;

  // The width is frozen once a message has started to carry text.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.line_width <= gwwc_pkg::LINE_WIDTH_RST;
      regs_q.max_chunks <= gwwc_pkg::MAX_CHUNKS_RST;
    end else if (we_i) begin
      unique case (idx_i)
        gwwc_pkg::CFG_LINE_WIDTH: begin
          if (!saw_text_i) begin
            regs_q.line_width <= wdata_i[gwwc_pkg::LINE_W-1:0];
          end
        end
        gwwc_pkg::CFG_MAX_CHUNKS: begin
          regs_q.max_chunks <= wdata_i[gwwc_pkg::MAXC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign regs_o = regs_q;

endmodule

@@ src/gwwc_core.sv @@
// ----------------------------------------------------------------------------
// gwwc_core
// Word and chunk buffers in two RAMs, with the sequencer that fills, copies
// and drains them, and the output register.
// ----------------------------------------------------------------------------
`include "greedy_word_wrap_chunker_unit_defines.svh"

module gwwc_core #(
  parameter int unsigned MAX_WIDTH = gwwc_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gwwc_pkg::cfg_regs_t cfg_i,
  output logic                saw_text_o,
  gwwc_in_if.sink             in_i,
  gwwc_out_if.source          out_o
);

  localparam int unsigned LEN_W = $clog2(MAX_WIDTH + 2);
  localparam int unsigned CAW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WAW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SUM_W = LEN_W + 2;

  typedef struct packed {
    logic [7:0] out_char;
    logic       no_char;
    logic [7:0] chunk_index;
    logic       end_of_chunk;
    logic       end_of_message;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHUNK_RD,
    S_CHUNK_WR,
    S_PIECE_RD,
    S_PIECE_WR,
    S_MOVE_RD,
    S_MOVE_WR,
    S_COMMIT,
    S_COPY_RD,
    S_COPY_WR,
    S_FINAL
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] cl_q, cl_d;
  logic [LEN_W-1:0] wl_q, wl_d;
  logic [7:0]       emitted_q, emitted_d;
  logic             saw_q, saw_d;
  logic             last_q, last_d;
  logic             commit_q, commit_d;
  logic             produced_q, produced_d;
  logic             final_q, final_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic             c_we, c_re;
  logic [CAW-1:0]   c_waddr, c_raddr;
  logic [7:0]       c_wdata, c_rdata;
  logic             w_we, w_re;
  logic [WAW-1:0]   w_waddr, w_raddr;
  logic [7:0]       w_wdata, w_rdata;

  logic [6:0]       lw_ext;
  logic [LEN_W-1:0] w_eff;
  logic             em_lt_max, em_last;
  logic             out_free, out_load, in_ready, clear_msg;
  logic             ws, append, flush_cond, piece_cond, eoc;
  logic [LEN_W-1:0] idx_inc, wl_new, mv_src, mv_len;
  state_e           st_after_main, st_after_commit;
  out_item_t        item_new;

  gwwc_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_chunk_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  gwwc_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH + 1)) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // Width in use: zero acts as one, large values saturate at MAX_WIDTH.
  assign lw_ext = {1'b0, cfg_i.line_width};
  always_comb begin
    if (cfg_i.line_width == '0) begin
      w_eff = LEN_W'(1);
    end else if (lw_ext > 7'(MAX_WIDTH)) begin
      w_eff = LEN_W'(MAX_WIDTH);
    end else begin
      w_eff = LEN_W'(lw_ext);
    end
  end

  assign em_lt_max = emitted_q < cfg_i.max_chunks;
  // True when the chunk now going out reaches the limit.
  assign em_last   = ({1'b0, emitted_q} + 9'd1) >= {1'b0, cfg_i.max_chunks};
  assign out_free  = !out_valid_q || out_o.ready;

  assign ws         = gwwc_pkg::is_space(in_i.in_char);
  assign append     = wl_q <= LEN_W'(MAX_WIDTH);
  assign wl_new     = append ? LEN_W'(wl_q + 1'b1) : wl_q;
  assign flush_cond = (cl_q != '0) &&
                      ((SUM_W'(cl_q) + SUM_W'(wl_new) + SUM_W'(1)) > SUM_W'(w_eff));
  assign piece_cond = (cl_q == '0) && (wl_new > w_eff);

  assign idx_inc = LEN_W'(idx_q + 1'b1);
  assign eoc     = idx_inc == w_eff;
  assign mv_src  = LEN_W'(w_eff + idx_q);
  assign mv_len  = LEN_W'(wl_q - w_eff);

  assign st_after_commit = last_q ? S_FINAL : S_IDLE;
  assign st_after_main   = commit_q ? S_COMMIT : st_after_commit;

  // Reads and writes alternate in RD/WR state pairs, so a read never meets a
  // write to the same entry in flight.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cl_d       = cl_q;
    wl_d       = wl_q;
    emitted_d  = emitted_q;
    saw_d      = saw_q;
    last_d     = last_q;
    commit_d   = commit_q;
    produced_d = produced_q;
    final_d    = final_q;
    clear_msg  = 1'b0;
    out_load   = 1'b0;
    item_new   = '0;
    in_ready   = 1'b0;
    c_we       = 1'b0;
    c_waddr    = cl_q[CAW-1:0];
    c_wdata    = gwwc_pkg::CH_SPACE;
    c_re       = 1'b0;
    c_raddr    = idx_q[CAW-1:0];
    w_we       = 1'b0;
    w_waddr    = idx_q[WAW-1:0];
    w_wdata    = in_i.in_char;
    w_re       = 1'b0;
    w_raddr    = idx_q[WAW-1:0];

    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          last_d     = in_i.in_last;
          commit_d   = 1'b0;
          produced_d = 1'b0;
          final_d    = 1'b0;
          idx_d      = '0;
          if (!ws) begin
            saw_d = 1'b1;
          end
          if (em_lt_max && !ws) begin
            if (append) begin
              w_we    = 1'b1;
              w_waddr = wl_q[WAW-1:0];
            end
            wl_d     = wl_new;
            commit_d = in_i.in_last;
            if (flush_cond) begin
              state_d = S_CHUNK_RD;
            end else if (piece_cond) begin
              state_d = S_PIECE_RD;
            end else if (in_i.in_last) begin
              state_d = S_COMMIT;
            end
          end else if (em_lt_max) begin
            state_d = S_COMMIT;
          end else if (in_i.in_last) begin
            state_d = S_FINAL;
          end
        end
      end

      S_CHUNK_RD: begin
        if (out_free) begin
          c_re    = 1'b1;
          state_d = S_CHUNK_WR;
        end
      end

      S_CHUNK_WR: begin
        out_load                = 1'b1;
        item_new.out_char       = (idx_q < cl_q) ? c_rdata : gwwc_pkg::CH_SPACE;
        item_new.chunk_index    = emitted_q;
        item_new.end_of_chunk   = eoc;
        item_new.end_of_message = eoc && (final_q || (last_q && em_last));
        if (eoc) begin
          emitted_d  = emitted_q + 8'd1;
          cl_d       = '0;
          produced_d = 1'b1;
          idx_d      = '0;
          if (final_q) begin
            clear_msg = 1'b1;
            state_d   = S_IDLE;
          end else begin
            state_d = st_after_main;
          end
        end else begin
          idx_d   = idx_inc;
          state_d = S_CHUNK_RD;
        end
      end

      S_PIECE_RD: begin
        if (out_free) begin
          w_re    = 1'b1;
          state_d = S_PIECE_WR;
        end
      end

      S_PIECE_WR: begin
        out_load                = 1'b1;
        item_new.out_char       = w_rdata;
        item_new.chunk_index    = emitted_q;
        item_new.end_of_chunk   = eoc;
        item_new.end_of_message = eoc && last_q && em_last;
        if (eoc) begin
          emitted_d  = emitted_q + 8'd1;
          produced_d = 1'b1;
          idx_d      = '0;
          state_d    = S_MOVE_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = S_PIECE_RD;
        end
      end

      // Shift the rest of an over-long word down to the front of the buffer.
      S_MOVE_RD: begin
        w_re    = 1'b1;
        w_raddr = mv_src[WAW-1:0];
        state_d = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        w_we    = 1'b1;
        w_wdata = w_rdata;
        if (idx_inc == mv_len) begin
          wl_d    = mv_len;
          idx_d   = '0;
          state_d = st_after_main;
        end else begin
          idx_d   = idx_inc;
          state_d = S_MOVE_RD;
        end
      end

      S_COMMIT: begin
        idx_d = '0;
        if (wl_q == '0) begin
          state_d = st_after_commit;
        end else begin
          if ((cl_q != '0) && (cl_q < LEN_W'(MAX_WIDTH))) begin
            c_we = 1'b1;
            cl_d = LEN_W'(cl_q + 1'b1);
          end
          state_d = S_COPY_RD;
        end
      end

      S_COPY_RD: begin
        w_re    = 1'b1;
        state_d = S_COPY_WR;
      end

      S_COPY_WR: begin
        if (cl_q < LEN_W'(MAX_WIDTH)) begin
          c_we    = 1'b1;
          c_wdata = w_rdata;
          cl_d    = LEN_W'(cl_q + 1'b1);
        end
        if (idx_inc == wl_q) begin
          wl_d    = '0;
          idx_d   = '0;
          state_d = st_after_commit;
        end else begin
          idx_d   = idx_inc;
          state_d = S_COPY_RD;
        end
      end

      S_FINAL: begin
        if (!saw_q) begin
          // A message of whitespace alone still gives one empty chunk.
          if (out_free) begin
            out_load                = 1'b1;
            item_new.no_char        = 1'b1;
            item_new.end_of_chunk   = 1'b1;
            item_new.end_of_message = 1'b1;
            clear_msg               = 1'b1;
            state_d                 = S_IDLE;
          end
        end else if ((cl_q != '0) && em_lt_max) begin
          final_d = 1'b1;
          idx_d   = '0;
          state_d = S_CHUNK_RD;
        end else if (!produced_q) begin
          // Nothing came out for the final byte: send a bare end marker.
          if (out_free) begin
            out_load                = 1'b1;
            item_new.no_char        = 1'b1;
            item_new.end_of_message = 1'b1;
            clear_msg               = 1'b1;
            state_d                 = S_IDLE;
          end
        end else begin
          clear_msg = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (clear_msg) begin
      cl_d      = '0;
      wl_d      = '0;
      emitted_d = '0;
      saw_d     = 1'b0;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);
  assign out_item_d  = out_load ? item_new : out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cl_q        <= '0;
      wl_q        <= '0;
      emitted_q   <= '0;
      saw_q       <= 1'b0;
      last_q      <= 1'b0;
      commit_q    <= 1'b0;
      produced_q  <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cl_q        <= cl_d;
      wl_q        <= wl_d;
      emitted_q   <= emitted_d;
      saw_q       <= saw_d;
      last_q      <= last_d;
      commit_q    <= commit_d;
      produced_q  <= produced_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign in_i.ready           = in_ready;
  assign saw_text_o           = saw_q;
  assign out_o.valid          = out_valid_q;
  assign out_o.out_char       = out_item_q.out_char;
  assign out_o.no_char        = out_item_q.no_char;
  assign out_o.chunk_index    = out_item_q.chunk_index;
  assign out_o.end_of_chunk   = out_item_q.end_of_chunk;
  assign out_o.end_of_message = out_item_q.end_of_message;

  `GWWC_ASSERT(a_load_slot_free, out_load |-> out_free, "output register overwritten")
  `GWWC_ASSERT(a_chunk_fits, cl_q <= w_eff, "chunk longer than the width in use")
  `GWWC_ASSERT(a_piece_long, (state_q == S_PIECE_RD) |-> (wl_q > w_eff), "piece of a short word")
  `GWWC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (state_q == S_IDLE && !out_valid_q), "not idle in reset")

endmodule

@@ src/greedy_word_wrap_chunker_unit.sv @@
// ----------------------------------------------------------------------------
// greedy_word_wrap_chunker_unit
// Packs a byte stream of words into fixed-width, space-padded chunks and
// streams the chunks out one character per transfer. A byte that only extends
// the current word is taken straight from the idle state. A separator commits
// the finished word, copied character by character from the word RAM into the
// chunk RAM. Each character of an emitted chunk is read from a buffer RAM with
// registered read data before it enters the output register, and a word cut at
// the width has its remainder moved down in the word RAM. The output register
// lets the next byte in while the final result of a message still waits.
// No clearing pass follows reset. The width register is ignored while a
// message with text is in progress; the chunk limit takes effect at once.
// ----------------------------------------------------------------------------
module greedy_word_wrap_chunker_unit #(
  parameter int unsigned MAX_WIDTH = gwwc_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gwwc_in_if.sink                         in_i,
  gwwc_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [gwwc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gwwc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  gwwc_pkg::cfg_regs_t cfg_regs;
  logic                saw_text;

  gwwc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (cfg_we_i),
    .idx_i      (cfg_idx_i),
    .wdata_i    (cfg_wdata_i),
    .saw_text_i (saw_text),
    .regs_o     (cfg_regs)
  );

  gwwc_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_regs),
    .saw_text_o (saw_text),
    .in_i       (in_i),
    .out_o      (out_o)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the greedy word wrap chunker
// Drives messages byte by byte into greedy_word_wrap_chunker_unit and checks
// every chunk character, empty chunk and end marker against a predictor that
// packs words the same way. Short directed tests cover separators, empty
// messages, width clamping, chunk limits, config writes in mid-message and
// spare register indexes. Random messages follow, first with idle bursts on
// both channels and then as a steady stream with no idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MAX_W         = gwwc_pkg::MAX_WIDTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned MAX_PRINTS    = 40;

  localparam logic [gwwc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [gwwc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       none;
    logic [7:0] idx;
    logic       eoc;
    logic       eom;
  } wrap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                            cfg_we;
  logic [gwwc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [gwwc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gwwc_in_if  in_if ();
  gwwc_out_if out_if ();

  greedy_word_wrap_chunker_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: the chunk and word being built, and the registers.
  logic [7:0]   line_buf [MAX_W];
  logic [7:0]   word_buf [MAX_W+1];
  int           line_len     = 0;
  int           word_len     = 0;
  logic [7:0]   chunks_done  = '0;
  bit           text_seen    = 1'b0;
  logic [5:0]   width_reg    = gwwc_pkg::LINE_WIDTH_RST;
  logic [7:0]   limit_reg    = gwwc_pkg::MAX_CHUNKS_RST;

  wrap_result_t step_chars [$];
  wrap_result_t pending_chars [$];

  int  errors        = 0;
  int  bytes_sent    = 0;
  int  messages_sent = 0;
  int  chars_checked = 0;
  bit  idle_en       = 1'b1;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic bit is_separator(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic none,
                                    input logic [7:0] idx, input logic eoc);
    wrap_result_t r;
    r = '{ch: ch, none: none, idx: idx, eoc: eoc, eom: 1'b0};
    step_chars.push_back(r);
  endfunction

  function automatic void flush_line(input int w);
    for (int i = 0; i < w; i++)
      push_char((i < line_len && i < MAX_W) ? line_buf[i] : gwwc_pkg::CH_SPACE, 1'b0,
                chunks_done, i + 1 == w);
    chunks_done++;
    line_len = 0;
  endfunction

  function automatic void commit_word();
    if (word_len == 0) return;
    if (line_len > 0 && line_len < MAX_W) begin
      line_buf[line_len] = gwwc_pkg::CH_SPACE;
      line_len++;
    end
    for (int i = 0; i < word_len; i++)
      if (line_len < MAX_W) begin
        line_buf[line_len] = word_buf[i];
        line_len++;
      end
    word_len = 0;
  endfunction

  // Works out the characters caused by one accepted byte.
  function automatic void wrap_byte(input logic [7:0] c, input logic last);
    int w;
    bit ws;
    w  = active_width();
    ws = is_separator(c);
    step_chars.delete();
    if (!ws) text_seen = 1'b1;
    if (chunks_done < limit_reg) begin
      if (ws) begin
        commit_word();
      end else begin
        if (word_len <= MAX_W) begin
          word_buf[word_len] = c;
          word_len++;
        end
        if (line_len > 0 && line_len + 1 + word_len > w) begin
          flush_line(w);
        end else if (line_len == 0 && word_len > w) begin
          // Cut a full-width piece off an overlong word.
          for (int i = 0; i < w; i++) push_char(word_buf[i], 1'b0, chunks_done, i + 1 == w);
          chunks_done++;
          for (int i = 0; i < word_len - w; i++) word_buf[i] = word_buf[i + w];
          word_len -= w;
        end
        if (last) commit_word();
      end
    end
    if (last) begin
      if (!text_seen) push_char(8'h00, 1'b1, 8'h00, 1'b1);
      else if (line_len > 0 && chunks_done < limit_reg) flush_line(w);
      if (step_chars.size() == 0) push_char(8'h00, 1'b1, 8'h00, 1'b0);
      step_chars[step_chars.size() - 1].eom = 1'b1;
      line_len    = 0;
      word_len    = 0;
      chunks_done = '0;
      text_seen   = 1'b0;
    end
    foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_char <= ch;
    in_if.in_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    wrap_byte(ch, last);
    bytes_sent++;
    if (last) messages_sent++;
  endtask

  task automatic send_text(input string s, input bit last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last && (i == s.len() - 1));
  endtask

  // Lets the block run dry: every result taken, then time for work that
  // produces no result.
  task automatic drain_block();
    in_if.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gwwc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gwwc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    if (idx == gwwc_pkg::CFG_LINE_WIDTH && !text_seen)
      width_reg = data[gwwc_pkg::LINE_W-1:0];
    else if (idx == gwwc_pkg::CFG_MAX_CHUNKS) limit_reg = data;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_separator();
    case ($urandom_range(0, 3))
      0:       return gwwc_pkg::CH_SPACE;
      1:       return gwwc_pkg::CH_TAB;
      2:       return gwwc_pkg::CH_LF;
      default: return gwwc_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_separator(b));
    return b;
  endfunction

  task automatic send_random_message();
    logic [7:0] msg [$];
    int w;
    int nwords;
    int wl;
    w = active_width();
    if ($urandom_range(0, 4) == 0) begin
      // Noise: arbitrary bytes, separators included.
      repeat ($urandom_range(1, 12))
        msg.push_back($urandom_range(0, 3) == 0 ? rand_separator() : 8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) msg.push_back(rand_separator());
      nwords = $urandom_range(0, 6);
      for (int k = 0; k < nwords; k++) begin
        if (k > 0) repeat ($urandom_range(1, 3)) msg.push_back(rand_separator());
        wl = ($urandom_range(0, 7) == 0) ? $urandom_range(w, 40) : $urandom_range(1, w + 1);
        repeat (wl) msg.push_back(rand_word_byte());
      end
      if ($urandom_range(0, 3) == 0) msg.push_back(rand_separator());
      if (msg.size() == 0) msg.push_back(rand_separator());
    end
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic randomize_config();
    bit set_w;
    bit set_l;
    bit set_s;
    logic [5:0] wv;
    logic [7:0] lv;
    set_w = $urandom_range(0, 2) == 0;
    set_l = $urandom_range(0, 3) == 0;
    set_s = $urandom_range(0, 15) == 0;
    if (!(set_w || set_l || set_s)) return;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: wv = 6'($urandom_range(1, 8));
      6:                wv = 6'($urandom_range(9, 20));
      7:                wv = 6'd32;
      8:                wv = 6'd0;
      default:          wv = 6'($urandom_range(33, 63));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: lv = 8'($urandom_range(5, 255));
      6, 7:             lv = 8'($urandom_range(1, 3));
      8:                lv = 8'd0;
      default:          lv = 8'd255;
    endcase
    drain_block();
    if (set_w) write_reg(gwwc_pkg::CFG_LINE_WIDTH, {2'b00, wv});
    if (set_l) write_reg(gwwc_pkg::CFG_MAX_CHUNKS, lv);
    if (set_s) write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_defaults();
    send_text("ab ", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_separators_and_empty();
    send_byte(gwwc_pkg::CH_TAB, 1'b0);
    send_byte(gwwc_pkg::CH_LF, 1'b0);
    send_byte(gwwc_pkg::CH_CR, 1'b1);
    send_byte(gwwc_pkg::CH_SPACE, 1'b1);
    send_byte("x", 1'b0);
    send_byte(gwwc_pkg::CH_CR, 1'b1);
  endtask

  task automatic test_width_clamp();
    drain_block();
    write_reg(gwwc_pkg::CFG_LINE_WIDTH, 8'd0);
    send_text("xy", 1'b1);
    drain_block();
    write_reg(gwwc_pkg::CFG_LINE_WIDTH, 8'd63);
    send_text("a", 1'b1);
    drain_block();
    write_reg(gwwc_pkg::CFG_LINE_WIDTH, 8'd33);
    send_text("q", 1'b1);
  endtask

  task automatic test_chunk_limit();
    drain_block();
    write_reg(gwwc_pkg::CFG_LINE_WIDTH, 8'd4);
    write_reg(gwwc_pkg::CFG_MAX_CHUNKS, 8'd1);
    // The first piece reaches the limit and the rest is thrown away.
    send_text("abcdef", 1'b1);
    drain_block();
    write_reg(gwwc_pkg::CFG_MAX_CHUNKS, 8'd0);
    send_text("a", 1'b1);
    send_byte(gwwc_pkg::CH_SPACE, 1'b1);
  endtask

  task automatic test_spare_index();
    drain_block();
    write_reg(gwwc_pkg::CFG_MAX_CHUNKS, 8'd255);
    write_reg(CFG_SPARE_A, 8'hFF);
    write_reg(CFG_SPARE_B, 8'hFF);
    send_text("z", 1'b1);
  endtask

  task automatic test_mid_message_config();
    drain_block();
    write_reg(gwwc_pkg::CFG_LINE_WIDTH, 8'd3);
    send_text("ab", 1'b0);
    drain_block();
    // The width is held once text has arrived; the limit applies at once.
    write_reg(gwwc_pkg::CFG_LINE_WIDTH, 8'd10);
    write_reg(gwwc_pkg::CFG_MAX_CHUNKS, 8'd2);
    send_text(" cd ef", 1'b1);
  endtask

  task automatic test_random_traffic();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 200) begin
      randomize_config();
      send_random_message();
    end
  endtask

  task automatic test_steady_stream();
    int start;
    drain_block();
    idle_en = 1'b0;
    start   = bytes_sent;
    while (bytes_sent - start < 50) begin
      randomize_config();
      send_random_message();
    end
  endtask

  // Result side: random stall bursts, with long runs of steady ready.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(0, 5) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
        @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    wrap_result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: char %02h idx %0d",
                                  out_if.out_char, out_if.chunk_index));
      end else begin
        exp_r = pending_chars.pop_front();
        chars_checked++;
        if (out_if.out_char !== exp_r.ch)
          report_mismatch($sformatf("out_char %02h, expected %02h (chunk %0d)",
                                    out_if.out_char, exp_r.ch, exp_r.idx));
        if (out_if.no_char !== exp_r.none)
          report_mismatch($sformatf("no_char %b, expected %b", out_if.no_char, exp_r.none));
        if (out_if.chunk_index !== exp_r.idx)
          report_mismatch($sformatf("chunk_index %0d, expected %0d",
                                    out_if.chunk_index, exp_r.idx));
        if (out_if.end_of_chunk !== exp_r.eoc)
          report_mismatch($sformatf("end_of_chunk %b, expected %b (chunk %0d)",
                                    out_if.end_of_chunk, exp_r.eoc, exp_r.idx));
        if (out_if.end_of_message !== exp_r.eom)
          report_mismatch($sformatf("end_of_message %b, expected %b (chunk %0d)",
                                    out_if.end_of_message, exp_r.eom, exp_r.idx));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results still expected", pending_chars.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_char <= 8'h00;
    in_if.in_last <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= gwwc_pkg::CFG_LINE_WIDTH;
    cfg_wdata     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_separators_and_empty();
    test_width_clamp();
    test_chunk_limit();
    test_spare_index();
    test_mid_message_config();
    test_random_traffic();
    test_steady_stream();

    drain_block();
    if (pending_chars.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_chars.size()));
    $display("Sent %0d messages in %0d bytes and checked %0d results.",
             messages_sent, bytes_sent, chars_checked);
    $display("Widths 0 to 63 and chunk limits 0 to 255 were used, with and without stalls.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/gwwc_pkg.sv
src/gwwc_in_if.sv
src/gwwc_out_if.sv
src/gwwc_ram.sv
src/gwwc_cfg.sv
src/gwwc_core.sv
src/greedy_word_wrap_chunker_unit.sv
dv/tb_top.sv
